>>> rtl/core/upd_pkg.sv
package upd_pkg;

  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] PrintLow  = 8'd32;
  localparam logic [7:0] PrintEnd  = 8'd127;
  localparam logic [3:0] HexAlphaBase = 4'd10;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_e;

  // Decode result handed from the decode stage to the output register.
  typedef struct packed {
    logic       produce;
    logic [7:0] out_byte;
    logic       has_char;
    logic       end_of_string;
    logic       decode_error;
  } result_t;

  // Hex digit of either case: {bad, value}; value is 0 when bad.
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = {1'b1, 4'd0};
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h61 && b <= 8'h66) begin
      r = {1'b0, 4'(HexAlphaBase + 4'(b - 8'h61))};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b0, 4'(HexAlphaBase + 4'(b - 8'h41))};
    end
    return r;
  endfunction

endpackage

>>> rtl/core/upd_decode.sv
module upd_decode (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       byte_i,
  input  logic             last_i,
  output upd_pkg::result_t res_o
);

  upd_pkg::phase_e phase_q, phase_d;
  logic [3:0]      nib_q, nib_d;
  logic            err_q, err_d;

  always_comb begin
    logic [4:0] hv;
    logic [7:0] ch;
    logic       emit;
    hv      = upd_pkg::hex_value(byte_i);
    ch      = 8'd0;
    emit    = 1'b0;
    phase_d = upd_pkg::PH_IDLE;
    nib_d   = nib_q;
    err_d   = err_q;
    unique case (phase_q)
      upd_pkg::PH_HIGH: begin
        err_d   = err_q | hv[4];
        nib_d   = hv[3:0];
        phase_d = upd_pkg::PH_LOW;
      end
      upd_pkg::PH_LOW: begin
        err_d = err_q | hv[4];
        ch    = {nib_q, hv[3:0]};
        emit  = !err_d && ch >= upd_pkg::PrintLow && ch < upd_pkg::PrintEnd;
      end
      default: begin
        if (byte_i == upd_pkg::PctChar) begin
          phase_d = upd_pkg::PH_HIGH;
        end else begin
          ch   = byte_i;
          emit = !err_q;
        end
      end
    endcase
    // string ends inside an escape
    if (last_i && phase_d != upd_pkg::PH_IDLE) begin
      err_d = 1'b1;
      emit  = 1'b0;
    end
    res_o.produce       = emit | last_i;
    res_o.out_byte      = emit ? ch : 8'd0;
    res_o.has_char      = emit;
    res_o.end_of_string = last_i;
    res_o.decode_error  = last_i & err_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= upd_pkg::PH_IDLE;
      nib_q   <= 4'd0;
      err_q   <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        phase_q <= upd_pkg::PH_IDLE;
        nib_q   <= 4'd0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        nib_q   <= nib_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

>>> rtl/core/uri_percent_decoder.sv
// Percent decoder for a byte stream, one character word per cycle unless out_ready_i stalls it.
// A result word passes the input register, then the result register; words
// that cause no result are dropped from the input register.
// Throughput: one word per cycle when the output is not stalled, set by the single decode stage and its state.
// Reset (rst_ni low, asynchronous): both stages empty, escape state cleared.
module uri_percent_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       has_char_o,
  output logic       end_of_string_o,
  output logic       decode_error_o
);

  logic             in_valid_q;
  logic [7:0]       in_byte_q;
  logic             in_last_q;
  logic             out_valid_q;
  upd_pkg::result_t out_q;
  upd_pkg::result_t res;
  logic             step;

  // advance the input word whenever the result slot is free or draining
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  upd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .last_i (in_last_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
      in_last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= res.produce;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res.produce) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_q.out_byte;
  assign has_char_o      = out_q.has_char;
  assign end_of_string_o = out_q.end_of_string;
  assign decode_error_o  = out_q.decode_error;

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int QuietLimit = 1000;
  localparam int HoldCycles = 80;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       eos;
    logic       err;
  } dec_word_t;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       has_char_o;
  logic       end_of_string_o;
  logic       decode_error_o;

  dec_word_t       decoded_q[$];
  upd_pkg::phase_e esc_phase = upd_pkg::PH_IDLE;
  logic [3:0]      hi_nibble = 4'd0;
  logic            str_err   = 1'b0;
  int              n_errors  = 0;
  int              quiet_cnt = 0;
  int              hold_cnt  = 0;
  bit              steady    = 1'b0;

  uri_percent_decoder i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .in_last_i      (in_last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .out_byte_o     (out_byte_o),
    .has_char_o     (has_char_o),
    .end_of_string_o(end_of_string_o),
    .decode_error_o (decode_error_o)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // {bad, value} of a hex digit of either case; value is 0 when bad
  function automatic logic [4:0] digit_of(input logic [7:0] b);
    if (b >= "0" && b <= "9") return {1'b0, 4'(b - "0")};
    if (b >= "a" && b <= "f") return {1'b0, 4'(b - "a" + 8'd10)};
    if (b >= "A" && b <= "F") return {1'b0, 4'(b - "A" + 8'd10)};
    return 5'b1_0000;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 4'd10) return 8'("0") + 8'(v);
    return (upper ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
  endfunction

  task automatic predict_word(input logic [7:0] b, input logic last);
    logic [4:0] nib;
    logic [7:0] ch;
    logic       emit;
    emit = 1'b0;
    ch   = b;
    case (esc_phase)
      upd_pkg::PH_HIGH: begin
        nib = digit_of(b);
        if (nib[4]) str_err = 1'b1;
        hi_nibble = nib[3:0];
        esc_phase = upd_pkg::PH_LOW;
      end
      upd_pkg::PH_LOW: begin
        nib = digit_of(b);
        if (nib[4]) str_err = 1'b1;
        ch   = {hi_nibble, nib[3:0]};
        emit = !str_err && ch >= upd_pkg::PrintLow && ch < upd_pkg::PrintEnd;
        esc_phase = upd_pkg::PH_IDLE;
      end
      default: begin
        if (b == upd_pkg::PctChar) begin
          esc_phase = upd_pkg::PH_HIGH;
        end else begin
          emit = !str_err;
          esc_phase = upd_pkg::PH_IDLE;
        end
      end
    endcase
    // string ends inside an escape
    if (last && esc_phase != upd_pkg::PH_IDLE) begin
      str_err = 1'b1;
      emit    = 1'b0;
    end
    if (emit || last) decoded_q.push_back('{emit ? ch : 8'h00, emit, last, last && str_err});
    if (last) begin
      esc_phase = upd_pkg::PH_IDLE;
      hi_nibble = 4'd0;
      str_err   = 1'b0;
    end
  endtask

  task automatic send_word(input logic [7:0] b, input logic last);
    while (!steady && $urandom_range(0, 99) < 19) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    in_last_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
    predict_word(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  // Mostly well-formed strings with random content, plus bad digits and cut escapes.
  task automatic send_random_strings(input int n_words);
    logic [7:0] str_q[$];
    int         sent;
    int         segs;
    int         r;
    logic [7:0] v;
    sent = 0;
    while (sent < n_words) begin
      str_q.delete();
      segs = $urandom_range(1, 10);
      for (int s = 0; s < segs; s++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          do v = 8'($urandom_range(32, 126)); while (v == upd_pkg::PctChar);
          str_q.push_back(v);
        end else if (r < 80) begin
          v = 8'($urandom_range(0, 255));
          str_q.push_back(upd_pkg::PctChar);
          str_q.push_back(hex_char(v[7:4], 1'($urandom_range(0, 1))));
          str_q.push_back(hex_char(v[3:0], 1'($urandom_range(0, 1))));
        end else if (r < 92) begin
          str_q.push_back(8'($urandom_range(0, 255)));
        end else if (r < 96) begin
          str_q.push_back(upd_pkg::PctChar);
          str_q.push_back(8'($urandom_range(0, 255)));
          str_q.push_back(8'($urandom_range(0, 255)));
        end else begin
          str_q.push_back(upd_pkg::PctChar);
        end
      end
      // cut the tail now and then, so a string may end inside an escape
      if ($urandom_range(0, 99) < 8 && str_q.size() > 2) begin
        void'(str_q.pop_back());
      end
      foreach (str_q[i]) send_word(str_q[i], i == str_q.size() - 1);
      sent += str_q.size();
    end
  endtask

  task automatic test_directed();
    send_text("A%41%7e");
    send_text("%7f%1F");
    send_text("%20");
    send_text("%");
    send_text("x%4");
    send_text("%g1z");
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b1);
  endtask

  task automatic test_streaming();
    steady = 1'b1;
    send_random_strings(120);
    steady = 1'b0;
  endtask

  task automatic test_backpressure();
    hold_cnt <= HoldCycles;
    steady   = 1'b1;
    send_random_strings(40);
    steady   = 1'b0;
  endtask

  task automatic test_random();
    send_random_strings(370);
  endtask

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      out_ready_i <= 1'b0;
      hold_cnt    <= hold_cnt - 1;
    end else begin
      out_ready_i <= steady || ($urandom_range(0, 99) >= 19);
    end
  end

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    n_errors++;
  endtask

  always @(posedge clk_i) begin : check_proc
    dec_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (decoded_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual byte %0h char %0b end %0b err %0b",
                 $time, out_byte_o, has_char_o, end_of_string_o, decode_error_o);
        n_errors++;
      end else begin
        want = decoded_q.pop_front();
        if (out_byte_o !== want.ch) report_field("out_byte", want.ch, out_byte_o);
        if (has_char_o !== want.has_char) report_field("has_char", want.has_char, has_char_o);
        if (end_of_string_o !== want.eos) report_field("end_of_string", want.eos, end_of_string_o);
        if (decode_error_o !== want.err) report_field("decode_error", want.err, decode_error_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cnt <= 0;
      end else if (quiet_cnt >= QuietLimit) begin
        $display("tb_top: errors");
        $finish;
      end else begin
        quiet_cnt <= quiet_cnt + 1;
      end
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_streaming();
    test_backpressure();
    test_random();
    in_valid_i <= 1'b0;
    // drain
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
